[sv/u16u8_pkg.sv]
package u16u8_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Top six bits of a surrogate code unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'h36;
    localparam logic [5:0] SURR_LOW_TAG  = 6'h37;

    localparam logic [20:0] LIMIT_ONE   = 21'h00007F;
    localparam logic [20:0] LIMIT_TWO   = 21'h0007FF;
    localparam logic [20:0] LIMIT_THREE = 21'h00FFFF;

    // 0x10000 expressed in units of 1024
    localparam logic [10:0] PLANE_BASE_KB = 11'd64;

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } unit_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_text;
    } byte_item_t;

    // One unit of work for the back end: an optional lone high surrogate
    // sent first, then a code point of len bytes (len may be zero).
    typedef struct packed {
        logic        has_prefix;
        logic [9:0]  prefix_bits;
        logic [20:0] point;
        logic [2:0]  len;
        logic        last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic held_valid;
    } front_status_t;

    function automatic logic [2:0] point_len(input logic [20:0] cp);
        logic [2:0] n;
        if (cp <= LIMIT_ONE)
            n = LEN_ONE;
        else if (cp <= LIMIT_TWO)
            n = LEN_TWO;
        else if (cp <= LIMIT_THREE)
            n = LEN_THREE;
        else
            n = LEN_FOUR;
        return n;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp,
                                            input logic [2:0]  len,
                                            input logic [2:0]  pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_ONE: b = {1'b0, cp[6:0]};
            LEN_TWO:
            begin
                if (pos == 3'd0)
                    b = LEAD_TWO | {3'b000, cp[10:6]};
                else
                    b = CONT_MARK | {2'b00, cp[5:0]};
            end
            LEN_THREE:
            begin
                unique case (pos)
                    3'd0:    b = LEAD_THREE | {4'h0, cp[15:12]};
                    3'd1:    b = CONT_MARK | {2'b00, cp[11:6]};
                    default: b = CONT_MARK | {2'b00, cp[5:0]};
                endcase
            end
            LEN_FOUR:
            begin
                unique case (pos)
                    3'd0:    b = LEAD_FOUR | {5'h00, cp[20:18]};
                    3'd1:    b = CONT_MARK | {2'b00, cp[17:12]};
                    3'd2:    b = CONT_MARK | {2'b00, cp[11:6]};
                    default: b = CONT_MARK | {2'b00, cp[5:0]};
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[sv/utf16_to_utf8_transcoder.sv]
// Path: the bytes of an accepted unit pass through the job queue and then the output register.
// Throughput: one output byte per cycle while the receiver pops; a unit produces 0 to 6
// bytes through the single-byte output register; input is taken every cycle while
// the job queue between front and back end has room (QUEUE_DEPTH entries).
// Reset: clears the held surrogate, the job queue and the output valid flag; no sweep.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  u16u8_pkg::unit_item_t   unit,
    input  logic                    pop,
    output logic                    empty,
    output u16u8_pkg::byte_item_t   octet
);
    import u16u8_pkg::*;

    logic          accept, job_push, job_pop;
    job_t          push_job, head_job;
    queue_status_t q_status;
    front_status_t f_status;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    u16u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .unit     (unit),
        .job_push (job_push),
        .job      (push_job),
        .status   (f_status)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (push_job),
        .rd     (job_pop),
        .rd_job (head_job),
        .status (q_status)
    );

    u16u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_avail (!q_status.empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .octet     (octet)
    );

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !q_status.empty)
        else $error("job queue read while empty");

    a_text_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && octet.end_of_text) |-> octet.end_of_run)
        else $error("end of text without end of run");

    a_last_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && unit.last_unit) |=> !f_status.held_valid)
        else $error("surrogate held after last unit");

endmodule

[sv/u16u8_front.sv]
module u16u8_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  u16u8_pkg::unit_item_t   unit,
    output logic                    job_push,
    output u16u8_pkg::job_t         job,
    output u16u8_pkg::front_status_t status
);
    import u16u8_pkg::*;

    logic       held_valid_reg, held_valid_next;
    logic [9:0] held_bits_reg, held_bits_next;
    logic       is_high, is_low, pair, hold_new;
    logic [10:0] plane;

    assign is_high  = (unit.code_unit[15:10] == SURR_HIGH_TAG);
    assign is_low   = (unit.code_unit[15:10] == SURR_LOW_TAG);
    assign pair     = held_valid_reg && is_low;
    assign hold_new = !pair && is_high && !unit.last_unit;
    assign plane    = {1'b0, held_bits_reg} + PLANE_BASE_KB;

    always_comb
    begin
        job.has_prefix  = held_valid_reg && !pair;
        job.prefix_bits = held_bits_reg;
        job.last        = unit.last_unit;
        if (pair)
        begin
            job.point = {plane, unit.code_unit[9:0]};
            job.len   = LEN_FOUR;
        end
        else if (hold_new)
        begin
            job.point = 21'd0;
            job.len   = LEN_NONE;
        end
        else
        begin
            job.point = {5'd0, unit.code_unit};
            job.len   = point_len({5'd0, unit.code_unit});
        end
    end

    // A fresh high surrogate with nothing held produces no bytes yet
    assign job_push = accept && (held_valid_reg || !hold_new);

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept)
        begin
            held_valid_next = hold_new;
            held_bits_next  = hold_new ? unit.code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

    assign status.held_valid = held_valid_reg;

endmodule

[sv/u16u8_queue.sv]
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr,
    input  u16u8_pkg::job_t           wr_job,
    input  logic                      rd,
    output u16u8_pkg::job_t           rd_job,
    output u16u8_pkg::queue_status_t  status
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign rd_job       = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slots[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/u16u8_back.sv]
module u16u8_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  u16u8_pkg::job_t           job,
    input  logic                      job_avail,
    output logic                      job_pop,
    input  logic                      pop,
    output logic                      empty,
    output u16u8_pkg::byte_item_t     octet
);
    import u16u8_pkg::*;

    localparam logic [2:0] PREFIX_LEN = 3'd3;

    logic       out_valid_reg, out_valid_next;
    byte_item_t out_reg;
    logic [2:0] idx_reg, idx_next;
    logic       advance, in_prefix, final_byte;
    logic [2:0] total, pos, sel_len;
    logic [20:0] sel_point;
    byte_item_t cur;

    assign total      = (job.has_prefix ? PREFIX_LEN : 3'd0) + job.len;
    assign final_byte = (idx_reg == total - 3'd1);
    assign in_prefix  = job.has_prefix && (idx_reg < PREFIX_LEN);

    always_comb
    begin
        if (in_prefix)
        begin
            sel_point = {5'd0, SURR_HIGH_TAG, job.prefix_bits};
            sel_len   = LEN_THREE;
            pos       = idx_reg;
        end
        else
        begin
            sel_point = job.point;
            sel_len   = job.len;
            pos       = idx_reg - (job.has_prefix ? PREFIX_LEN : 3'd0);
        end
    end

    assign cur.out_byte    = enc_byte(sel_point, sel_len, pos);
    assign cur.end_of_run  = final_byte;
    assign cur.end_of_text = final_byte && job.last;

    // Advance when a job is available and the output word is free or being taken this cycle
    assign advance = job_avail && (!out_valid_reg || pop);
    assign job_pop = advance && final_byte;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            idx_next       = final_byte ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= cur;
    end

    assign empty = !out_valid_reg;
    assign octet = out_reg;

endmodule

[sim/tb_utf16_to_utf8_transcoder.sv]
module tb_utf16_to_utf8_transcoder;

    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_GAP     = 30;
    localparam int HOLD_OFF    = 300;
    localparam int DRAIN_WAIT  = 20;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    unit_item_t unit;
    logic       pop;
    logic       empty;
    byte_item_t octet;

    utf16_to_utf8_transcoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .unit  (unit),
        .pop   (pop),
        .empty (empty),
        .octet (octet)
    );

    // Predicted UTF-8 stream, oldest byte first
    byte_item_t utf8_expected[$];
    byte_item_t unit_bytes[$];

    // Surrogate held by the predictor
    logic [9:0] held_bits;
    logic       held_valid;

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_left;
    int quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic void put_byte(input logic [7:0] b);
        byte_item_t item;
        item.out_byte    = b;
        item.end_of_run  = 1'b0;
        item.end_of_text = 1'b0;
        unit_bytes.insert(unit_bytes.size(), item);
    endfunction

    function automatic void encode_point(input logic [20:0] cp);
        if (cp <= LIMIT_ONE)
        begin
            put_byte({1'b0, cp[6:0]});
        end
        else if (cp <= LIMIT_TWO)
        begin
            put_byte(LEAD_TWO | {3'b000, cp[10:6]});
            put_byte(CONT_MARK | {2'b00, cp[5:0]});
        end
        else if (cp <= LIMIT_THREE)
        begin
            put_byte(LEAD_THREE | {4'h0, cp[15:12]});
            put_byte(CONT_MARK | {2'b00, cp[11:6]});
            put_byte(CONT_MARK | {2'b00, cp[5:0]});
        end
        else
        begin
            put_byte(LEAD_FOUR | {5'h00, cp[20:18]});
            put_byte(CONT_MARK | {2'b00, cp[17:12]});
            put_byte(CONT_MARK | {2'b00, cp[11:6]});
            put_byte(CONT_MARK | {2'b00, cp[5:0]});
        end
    endfunction

    // Work out the bytes one accepted code unit releases
    function automatic void predict_utf8(input unit_item_t u);
        logic is_high;
        logic is_low;
        is_high = (u.code_unit[15:10] == SURR_HIGH_TAG);
        is_low  = (u.code_unit[15:10] == SURR_LOW_TAG);
        unit_bytes.delete();
        if (held_valid && is_low)
        begin
            encode_point(21'h10000 + {1'b0, held_bits, u.code_unit[9:0]});
            held_valid = 1'b0;
            held_bits  = '0;
        end
        else
        begin
            if (held_valid)
            begin
                encode_point({5'd0, SURR_HIGH_TAG, held_bits});
                held_valid = 1'b0;
                held_bits  = '0;
            end
            if (is_high && !u.last_unit)
            begin
                held_bits  = u.code_unit[9:0];
                held_valid = 1'b1;
            end
            else
            begin
                encode_point({5'd0, u.code_unit});
            end
        end
        if (unit_bytes.size() > 0)
        begin
            unit_bytes[unit_bytes.size() - 1].end_of_run  = 1'b1;
            unit_bytes[unit_bytes.size() - 1].end_of_text = u.last_unit;
        end
        foreach (unit_bytes[i])
            utf8_expected.insert(utf8_expected.size(), unit_bytes[i]);
    endfunction

    // Offer one code unit; push stays high on return so back-to-back words need no toggle
    task automatic send_unit(input logic [15:0] cu, input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        unit.code_unit <= cu;
        unit.last_unit <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_utf8('{code_unit: cu, last_unit: last});
    endtask

    task automatic stop_sending();
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (utf8_expected.size() != 0);
    endtask

    function automatic logic [15:0] pick_non_surrogate(input logic [15:0] lo_bound,
                                                       input logic [15:0] hi_bound);
        logic [15:0] cu;
        do
            cu = 16'($urandom_range(hi_bound, lo_bound));
        while (cu[15:11] == 5'b11011);
        return cu;
    endfunction

    // Random strings: mostly valid text and surrogate pairs, some lone surrogates and noise
    task automatic send_random_text(input int unit_total);
        logic [15:0] text[$];
        int          sent;
        int          len;
        sent = 0;
        while (sent < unit_total)
        begin
            text.delete();
            len = $urandom_range(8, 1);
            while (text.size() < len)
            begin
                case ($urandom_range(9))
                    0, 1:    text.insert(text.size(), 16'($urandom_range(16'h007F)));
                    2:       text.insert(text.size(), 16'($urandom_range(16'h07FF, 16'h0080)));
                    3:       text.insert(text.size(), pick_non_surrogate(16'h0800, 16'hFFFF));
                    4, 5, 6:
                    begin
                        text.insert(text.size(), {SURR_HIGH_TAG, 10'($urandom)});
                        text.insert(text.size(), {SURR_LOW_TAG, 10'($urandom)});
                    end
                    7:       text.insert(text.size(), {SURR_HIGH_TAG, 10'($urandom)});
                    8:       text.insert(text.size(), {SURR_LOW_TAG, 10'($urandom)});
                    default: text.insert(text.size(), 16'($urandom));
                endcase
            end
            foreach (text[i])
                send_unit(text[i], i == text.size() - 1);
            sent += text.size();
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 37;
        recv_idle_pct = 81;
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b1);
        // Lowest and highest supplementary code points
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Held high surrogate broken by a plain unit
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        // Held high surrogate broken by another high surrogate that then pairs
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        // High surrogate at end of string
        send_unit(16'hDABC, 1'b1);
        // Lone low surrogate
        send_unit(16'hDC00, 1'b0);
        // Held high surrogate, then the string ends on a plain unit
        send_unit(16'hD801, 1'b0);
        send_unit(16'h0020, 1'b1);
        // Held high surrogate, then a high surrogate marked last: six bytes
        send_unit(16'hDB00, 1'b0);
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hDFFF, 1'b1);
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 37;
        recv_idle_pct = 81;
        send_random_text(30);
        send_idle_pct = 81;
        recv_idle_pct = 37;
        send_random_text(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_text(25);
    endtask

    // Receiver holds off while words keep coming: the job queue must fill and stall input
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = HOLD_OFF;
        send_random_text(20);
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_random_text(10);
        stop_sending();
        wait_drained();
        send_random_text(10);
    endtask

    // Receiver: random pop, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left = hold_off_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_bytes
        byte_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (utf8_expected.size() == 0)
            begin
                report_mismatch("unexpected word", octet, 0);
            end
            else
            begin
                want = utf8_expected.pop_front();
                if (octet.out_byte !== want.out_byte)
                    report_mismatch("out_byte", octet.out_byte, want.out_byte);
                if (octet.end_of_run !== want.end_of_run)
                    report_mismatch("end_of_run", octet.end_of_run, want.end_of_run);
                if (octet.end_of_text !== want.end_of_text)
                    report_mismatch("end_of_text", octet.end_of_text, want.end_of_text);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        unit           = '0;
        pop            = 1'b0;
        held_bits      = '0;
        held_valid     = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_off_left  = 0;
        quiet_cycles   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_output_stall();
        test_pause_until_drained();

        stop_sending();
        recv_idle_pct = 0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
